### src/bls_pkg.sv
// Shared types and codes for the bounded LIFO stack.
`default_nettype none
package bls_pkg;

    localparam int DATA_W  = 32;
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 6;
    localparam int CAP_W   = 6;

    localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

    localparam logic [MODE_W-1:0] MODE_PUSH      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DUMP_UP   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_DUMP_DOWN = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]        mode;
        logic signed [DATA_W-1:0] push_value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] data_value;
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
        logic                     last;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic exec;
        logic dump_emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic req_dump;
        logic cnt_zero;
        logic dump_final;
    } t_sts;

endpackage
`default_nettype wire

### src/bls_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bls_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### src/bls_datapath.sv
// Stack datapath: count, capacity, entry RAM, dump walk and output register.
`default_nettype none
module bls_datapath #(
    parameter int DEPTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bls_pkg::t_cmd                  i_cmd,
    output bls_pkg::t_sts                       o_sts,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bls_pkg::CAP_W-1:0]      i_cfg_wr_data,
    input  wire bls_pkg::t_req                  i_req,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output bls_pkg::t_rsp                       o_rsp
);
    import bls_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [CAP_W-1:0]  r_cap;
    logic [CW-1:0]     r_count, n_count;
    logic [MODE_W-1:0] r_mode;
    logic [DATA_W-1:0] r_value;
    logic [AW-1:0]     r_ptr;
    logic [CW-1:0]     r_left;
    logic              r_out_valid;
    t_rsp              r_rsp, n_rsp;

    logic [AW-1:0]     top_addr, start_addr, ptr_step, rd_addr;
    logic              rd_en, wr_en, room, cnt_zero, emit;
    logic [DATA_W-1:0] rd_data;
    logic [DATA_W-1:0] res_data;
    logic [STAT_W-1:0] res_status;

    bls_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (r_value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign cnt_zero   = (r_count == '0);
    assign top_addr   = r_count[AW-1:0] - AW'(1);
    assign start_addr = (i_req.mode == MODE_DUMP_UP) ? '0 : top_addr;
    assign ptr_step   = (r_mode == MODE_DUMP_UP) ? r_ptr + AW'(1) : r_ptr - AW'(1);
    assign rd_en      = i_cmd.load | i_cmd.dump_emit;
    assign rd_addr    = i_cmd.load ? start_addr : ptr_step;
    assign room       = (8'(r_count) < 8'(r_cap)) && (r_count < DEPTH_C);
    assign emit       = i_cmd.exec | i_cmd.dump_emit;

    always_comb begin
        n_count    = r_count;
        wr_en      = 1'b0;
        res_data   = '0;
        res_status = ST_OK;
        if (i_cmd.exec) begin
            unique case (r_mode)
                MODE_PUSH: begin
                    if (room) begin
                        wr_en   = 1'b1;
                        n_count = r_count + CW'(1);
                    end else begin
                        res_status = ST_FULL;
                    end
                end
                MODE_POP: begin
                    if (cnt_zero) begin
                        res_status = ST_EMPTY;
                    end else begin
                        n_count  = r_count - CW'(1);
                        res_data = rd_data;
                    end
                end
                MODE_PEEK: begin
                    if (cnt_zero) begin
                        res_status = ST_EMPTY;
                    end else begin
                        res_data = rd_data;
                    end
                end
                MODE_CLEAR: begin
                    n_count = '0;
                end
                MODE_DUMP_UP, MODE_DUMP_DOWN: begin
                    res_status = ST_EMPTY;
                end
                default: begin
                end
            endcase
        end else if (i_cmd.dump_emit) begin
            res_data = rd_data;
        end
    end

    always_comb begin
        n_rsp.data_value  = res_data;
        n_rsp.status      = res_status;
        n_rsp.entry_count = CNT_W'(n_count);
        n_rsp.is_empty    = (n_count == '0);
        n_rsp.last        = i_cmd.exec | (r_left == CW'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            r_count <= n_count;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_req.mode;
            r_value <= i_req.push_value;
            r_ptr   <= start_addr;
            r_left  <= r_count;
        end else if (i_cmd.dump_emit) begin
            r_ptr  <= ptr_step;
            r_left <= r_left - CW'(1);
        end
        if (emit) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_sts.out_free   = ~r_out_valid | i_out_ready;
    assign o_sts.req_dump   = (i_req.mode == MODE_DUMP_UP) || (i_req.mode == MODE_DUMP_DOWN);
    assign o_sts.cnt_zero   = cnt_zero;
    assign o_sts.dump_final = (r_left == CW'(1));
    assign o_out_valid      = r_out_valid;
    assign o_rsp            = r_rsp;

endmodule
`default_nettype wire

### src/bls_ctrl.sv
// Request sequencer for the stack: accept, single execute, dump walk.
`default_nettype none
module bls_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire bls_pkg::t_sts i_sts,
    output bls_pkg::t_cmd      o_cmd
);
    import bls_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DUMP = 3'b100
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.exec      = 1'b0;
        o_cmd.dump_emit = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = (i_sts.req_dump && !i_sts.cnt_zero) ? S_DUMP : S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_DUMP: begin
                if (i_sts.out_free) begin
                    o_cmd.dump_emit = 1'b1;
                    if (i_sts.dump_final) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule
`default_nettype wire

### src/bounded_lifo_stack.sv
// Bounded LIFO stack top level: sequencer plus datapath.
//
// Requests enter on i_in_valid/o_in_ready with a mode and a push word;
// results leave on o_out_valid/i_out_ready, each with data, status, count,
// empty flag and last. Capacity is written through i_cfg_wr_en/i_cfg_wr_data;
// the user must do so only while the stack is idle; the block does not enforce
// it. Reset sets it to 32 and empties the stack. Push, pop, peek, clear and
// empty dumps give one result: a request is accepted, starting the RAM read,
// then executed once the output register is free. A dump's N entries leave one
// entry per cycle out of the single RAM read port. A result sits in the output
// register; when the receiver stalls the sequencer holds its state and the
// RAM read data until the register frees. Requests are taken one at a time:
// o_in_ready is high only between requests. Entries are never cleared; the
// count alone says which are live. Reset is synchronous and active low.
`default_nettype none
module bounded_lifo_stack #(
    parameter int DEPTH = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [bls_pkg::CAP_W-1:0] i_cfg_wr_data,
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire bls_pkg::t_req             i_in,
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output bls_pkg::t_rsp                  o_out
);
    import bls_pkg::*;

    t_cmd cmd;
    t_sts sts;

    bls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bls_datapath #(.DEPTH(DEPTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (i_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_rsp         (o_out)
    );

endmodule
`default_nettype wire

### src/bls_checker.sv
// Port-level checks for the bounded LIFO stack and their bind.
`default_nettype none
module bls_checker #(
    parameter int DEPTH = 32
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire bls_pkg::t_rsp o_out
);
    import bls_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> 32'(o_out.entry_count) <= DEPTH)
        else $error("entry count above depth");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.is_empty == (o_out.entry_count == '0))
        else $error("empty flag disagrees with count");

    a_error_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status != ST_OK |-> o_out.last && o_out.data_value == '0)
        else $error("error result not single or carries data");

endmodule

bind bounded_lifo_stack bls_checker #(.DEPTH(DEPTH)) u_bls_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
`default_nettype wire

### test/tb_bounded_lifo_stack.sv
// Self-checking testbench for the bounded LIFO stack: directed table, then randomized phases.
`default_nettype none
module tb_bounded_lifo_stack;
    timeunit 1ns;
    timeprecision 1ps;

    import bls_pkg::*;

    localparam int STACK_DEPTH = 32;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEMS_PER_PHASE = 55;
    localparam int N_PHASES = 8;
    localparam int MAX_REPORTS = 10;

    localparam logic [MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD7 = 3'd7;

    typedef struct {
        bit                 is_cfg;
        int                 cap;
        t_req               req;
        bit                 fixed;
        t_rsp               rsp;
    } t_step;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [CAP_W-1:0]  i_cfg_wr_data;
    logic              i_in_valid;
    logic              o_in_ready;
    t_req              i_in;
    logic              o_out_valid;
    logic              i_out_ready;
    t_rsp              o_out;

    bounded_lifo_stack #(
        .DEPTH(STACK_DEPTH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in         (i_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out        (o_out)
    );

    // shadow of the stack
    logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
    int                       shadow_count;
    int                       shadow_cap;

    t_rsp  op_rsp[$];
    t_rsp  due_rsp[$];
    t_step dir_rows[$];

    int fail_count;
    int cycle_count;
    int send_idle_pct;
    int stall_pct;

    int ph_idle [N_PHASES] = '{0, 70, 0, 31, 0, 70, 0, 31};
    int ph_stall[N_PHASES] = '{0, 0, 70, 31, 0, 0, 70, 31};
    int ph_cap  [N_PHASES] = '{63, 40, 5, 0, 1, 17, 32, 9};
    int ph_push [N_PHASES] = '{85, 50, 50, 40, 50, 60, 85, 50};

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_rsp.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result: data=%0d st=%0d cnt=%0d emp=%0b last=%0b",
                             o_out.data_value, o_out.status, o_out.entry_count,
                             o_out.is_empty, o_out.last);
            end else begin
                want = due_rsp.pop_front();
                if (o_out.data_value !== want.data_value || o_out.status !== want.status ||
                    o_out.entry_count !== want.entry_count ||
                    o_out.is_empty !== want.is_empty || o_out.last !== want.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"mismatch: exp data=%0d st=%0d cnt=%0d emp=%0b last=%0b",
                                  " | got data=%0d st=%0d cnt=%0d emp=%0b last=%0b"},
                                 want.data_value, want.status, want.entry_count,
                                 want.is_empty, want.last,
                                 o_out.data_value, o_out.status, o_out.entry_count,
                                 o_out.is_empty, o_out.last);
                end
            end
        end
    end

    // computes the results of one request and updates the shadow stack
    task automatic apply_stack_op(input t_req r);
        int   eff;
        t_rsp o;
        op_rsp = {};
        eff = (shadow_cap > STACK_DEPTH) ? STACK_DEPTH : shadow_cap;
        o = '0;
        o.last = 1'b1;
        case (r.mode)
            MODE_PUSH: begin
                if (shadow_count < eff) begin
                    shadow_words[shadow_count] = r.push_value;
                    shadow_count++;
                end else begin
                    o.status = ST_FULL;
                end
            end
            MODE_POP: begin
                if (shadow_count == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                    o.data_value = shadow_words[shadow_count];
                end
            end
            MODE_PEEK: begin
                if (shadow_count == 0)
                    o.status = ST_EMPTY;
                else
                    o.data_value = shadow_words[shadow_count - 1];
            end
            MODE_CLEAR: begin
                shadow_count = 0;
            end
            MODE_DUMP_UP, MODE_DUMP_DOWN: begin
                if (shadow_count == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i < shadow_count; i++) begin
                        o.data_value = (r.mode == MODE_DUMP_UP) ? shadow_words[i]
                                                                : shadow_words[shadow_count - 1 - i];
                        o.entry_count = CNT_W'(shadow_count);
                        o.is_empty = 1'b0;
                        o.last = (i == shadow_count - 1);
                        op_rsp.push_back(o);
                    end
                    return;
                end
            end
            default: begin
            end
        endcase
        o.entry_count = CNT_W'(shadow_count);
        o.is_empty = (shadow_count == 0);
        op_rsp.push_back(o);
    endtask

    // called at a falling edge; returns at a falling edge with valid still high
    task automatic send_req(input t_req r, input bit fixed, input t_rsp fixed_rsp);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= r;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        apply_stack_op(r);
        if (fixed)
            due_rsp.push_back(fixed_rsp);
        else
            foreach (op_rsp[k])
                due_rsp.push_back(op_rsp[k]);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (due_rsp.size() != 0);
    endtask

    task automatic write_capacity(input int cap);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= CAP_W'(cap);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        shadow_cap = cap;
    endtask

    function automatic t_rsp fixed_rsp(input logic [STAT_W-1:0] st, input int cnt);
        t_rsp o;
        o = '0;
        o.status = st;
        o.entry_count = CNT_W'(cnt);
        o.is_empty = (cnt == 0);
        o.last = 1'b1;
        return o;
    endfunction

    function automatic t_step req_row(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v);
        t_step s;
        s.is_cfg = 1'b0;
        s.cap = 0;
        s.req.mode = m;
        s.req.push_value = v;
        s.fixed = 1'b0;
        s.rsp = '0;
        return s;
    endfunction

    function automatic t_step chk_row(input logic [MODE_W-1:0] m, input logic [DATA_W-1:0] v,
                                      input t_rsp o);
        t_step s;
        s = req_row(m, v);
        s.fixed = 1'b1;
        s.rsp = o;
        return s;
    endfunction

    function automatic t_step cap_row(input int cap);
        t_step s;
        s = req_row(MODE_PUSH, '0);
        s.is_cfg = 1'b1;
        s.cap = cap;
        return s;
    endfunction

    function automatic t_req rand_req(input int push_pct);
        t_req r;
        int   pick;
        pick = $urandom_range(99);
        if (pick < push_pct)
            r.mode = MODE_PUSH;
        else
            r.mode = MODE_W'($urandom_range(7, 1));
        pick = $urandom_range(99);
        if (pick < 8)
            r.push_value = 32'h7FFF_FFFF;
        else if (pick < 16)
            r.push_value = 32'h8000_0000;
        else if (pick < 20)
            r.push_value = '1;
        else if (pick < 24)
            r.push_value = '0;
        else
            r.push_value = $urandom;
        return r;
    endfunction

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        shadow_count = 0;
        shadow_cap = int'(CAP_RESET);

        // empty stack, reserved modes, word extremes
        dir_rows.push_back(chk_row(MODE_POP, '0, fixed_rsp(ST_EMPTY, 0)));
        dir_rows.push_back(chk_row(MODE_PEEK, '0, fixed_rsp(ST_EMPTY, 0)));
        dir_rows.push_back(chk_row(MODE_DUMP_UP, '0, fixed_rsp(ST_EMPTY, 0)));
        dir_rows.push_back(chk_row(MODE_DUMP_DOWN, '0, fixed_rsp(ST_EMPTY, 0)));
        dir_rows.push_back(chk_row(MODE_RSVD6, '1, fixed_rsp(ST_OK, 0)));
        dir_rows.push_back(chk_row(MODE_RSVD7, '0, fixed_rsp(ST_OK, 0)));
        dir_rows.push_back(chk_row(MODE_PUSH, 32'h7FFF_FFFF, fixed_rsp(ST_OK, 1)));
        dir_rows.push_back(chk_row(MODE_PUSH, 32'h8000_0000, fixed_rsp(ST_OK, 2)));
        dir_rows.push_back(chk_row(MODE_PUSH, 32'hFFFF_FFFF, fixed_rsp(ST_OK, 3)));
        dir_rows.push_back(req_row(MODE_PEEK, '0));
        dir_rows.push_back(req_row(MODE_DUMP_UP, '0));
        dir_rows.push_back(req_row(MODE_DUMP_DOWN, '0));
        // capacity dropped below the fill level
        dir_rows.push_back(cap_row(2));
        dir_rows.push_back(chk_row(MODE_PUSH, '0, fixed_rsp(ST_FULL, 3)));
        dir_rows.push_back(req_row(MODE_POP, '0));
        dir_rows.push_back(chk_row(MODE_PUSH, '0, fixed_rsp(ST_FULL, 2)));
        dir_rows.push_back(req_row(MODE_POP, '0));
        dir_rows.push_back(chk_row(MODE_PUSH, '0, fixed_rsp(ST_OK, 2)));
        dir_rows.push_back(chk_row(MODE_CLEAR, '1, fixed_rsp(ST_OK, 0)));
        // zero capacity
        dir_rows.push_back(cap_row(0));
        dir_rows.push_back(chk_row(MODE_PUSH, 32'h1, fixed_rsp(ST_FULL, 0)));
        dir_rows.push_back(cap_row(1));
        dir_rows.push_back(chk_row(MODE_PUSH, 32'h5555_5555, fixed_rsp(ST_OK, 1)));
        dir_rows.push_back(chk_row(MODE_PUSH, 32'hAAAA_AAAA, fixed_rsp(ST_FULL, 1)));
        dir_rows.push_back(req_row(MODE_POP, '0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                drain_results();
                write_capacity(dir_rows[k].cap);
            end else begin
                send_req(dir_rows[k].req, dir_rows[k].fixed, dir_rows[k].rsp);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            send_idle_pct = ph_idle[p];
            stall_pct = ph_stall[p];
            write_capacity(ph_cap[p]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_req(rand_req(ph_push[p]), 1'b0, '0);
            end
        end

        drain_results();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
src/bls_pkg.sv
src/bls_ram.sv
src/bls_datapath.sv
src/bls_ctrl.sv
src/bounded_lifo_stack.sv
src/bls_checker.sv
test/tb_bounded_lifo_stack.sv
